>>> rtl/chol_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chol_pkg
// Shared types and constants of the Cholesky factorizer.
// ----------------------------------------------------------------------------
package chol_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_ACC_RD,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_SAT,
        ST_SQRT,
        ST_DIV,
        ST_WRITE,
        ST_OUT_RD,
        ST_OUT_WAIT
    } t_state;

    typedef struct packed {
        logic load_wr;
        logic clr_acc;
        logic acc_rd;
        logic acc_mul;
        logic acc_add;
        logic sat;
        logic sqrt_start;
        logic div_start;
        logic wr_factor;
        logic out_rd;
        logic [2:0] i;
        logic [2:0] j;
        logic [2:0] k;
        logic [5:0] load_addr;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic pivot_pos;
    } t_status;

endpackage : chol_pkg
`default_nettype wire

>>> rtl/chol_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chol_datapath
// Stores, multiply-accumulate, root and divide units of the factorizer.
// ----------------------------------------------------------------------------
module chol_datapath #(
    parameter int MAX_N     = 8,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire chol_pkg::t_cmd      i_cmd,
    input  wire logic signed [31:0]  i_data,
    output chol_pkg::t_status        o_status,
    output logic signed [31:0]       o_rd_data
);
    localparam int AW = 6;

    logic [31:0] r_in_mem [0:MAX_N*MAX_N-1];
    logic [31:0] r_fac_mem [0:MAX_N*MAX_N-1];
    logic [31:0] r_work [0:MAX_N-1];

    logic [AW-1:0] a_ji, a_ik, a_jk;
    always_comb begin
        a_ji = AW'({3'd0, i_cmd.j} * 6'(MAX_N) + {3'd0, i_cmd.i});
        a_ik = AW'({3'd0, i_cmd.i} * 6'(MAX_N) + {3'd0, i_cmd.k});
        a_jk = AW'({3'd0, i_cmd.j} * 6'(MAX_N) + {3'd0, i_cmd.k});
    end

    logic signed [31:0] r_fa, r_fb, r_ain;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_v;
    logic signed [31:0] r_fac_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) r_in_mem[i_cmd.load_addr] <= i_data;
        if (i_cmd.clr_acc) r_ain <= r_in_mem[i_cmd.load_addr];
        if (i_cmd.acc_rd) begin
            r_fa <= r_fac_mem[a_ik];
            r_fb <= r_fac_mem[a_jk];
        end
        if (i_cmd.out_rd) r_fac_q <= r_fac_mem[i_cmd.load_addr];
        if (i_cmd.acc_mul) r_prod <= r_fa * r_fb;
    end

    logic signed [63:0] rnd;
    always_comb begin
        if (FRAC_BITS > 0)
            rnd = (r_prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        else
            rnd = r_prod;
    end

    logic signed [63:0] ain_ext;
    assign ain_ext = 64'(r_ain);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) r_acc <= 64'sd0;
        else if (i_cmd.acc_add) r_acc <= r_acc - rnd;
        if (i_cmd.sat) begin
            if (ain_ext + r_acc > 64'sd2147483647) r_v <= 32'sh7fffffff;
            else if (ain_ext + r_acc < -64'sd2147483648) r_v <= 32'sh80000000;
            else r_v <= 32'(ain_ext + r_acc);
        end
        if (i_cmd.sat) begin
            if (ain_ext + r_acc > 64'sd2147483647) r_work[i_cmd.j] <= 32'h7fffffff;
            else if (ain_ext + r_acc < -64'sd2147483648) r_work[i_cmd.j] <= 32'h80000000;
            else r_work[i_cmd.j] <= 32'(ain_ext + r_acc);
        end
    end

    logic signed [31:0] pivot;
    assign pivot = r_work[i_cmd.i];
    assign o_status.pivot_pos = pivot > 32'sd0;

    // bit-serial integer square root of pivot << FRAC_BITS
    logic [63:0] r_sx, r_sres, r_sbit;
    logic        r_sbusy, r_sdone;
    logic [31:0] r_root;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbusy <= 1'b0;
            r_sdone <= 1'b0;
        end else if (i_cmd.sqrt_start) begin
            r_sx    <= 64'(pivot) << FRAC_BITS;
            r_sres  <= 64'd0;
            r_sbit  <= 64'd1 << 62;
            r_sbusy <= 1'b1;
            r_sdone <= 1'b0;
        end else if (r_sbusy) begin
            if (r_sbit == 64'd0) begin
                r_sbusy <= 1'b0;
                r_sdone <= 1'b1;
                r_root  <= r_sres[31:0];
            end else begin
                if (r_sx >= r_sres + r_sbit) begin
                    r_sx   <= r_sx - (r_sres + r_sbit);
                    r_sres <= (r_sres >> 1) + r_sbit;
                end else begin
                    r_sres <= r_sres >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
        end
    end
    assign o_status.sqrt_done = r_sdone;

    // restoring divider: (|v| << FRAC_BITS + s/2) / s
    logic [63:0] r_dnum, r_drem;
    logic [6:0]  r_dcnt;
    logic        r_dbusy, r_ddone, r_dneg;
    logic [31:0] r_q32;
    logic [64:0] trial;
    logic [63:0] mag;
    assign mag = r_v[31] ? 64'(-64'(r_v)) : 64'(r_v);
    assign trial = {r_drem, r_dnum[63]} - {33'd0, r_root};

    logic [63:0] q_fin;
    assign q_fin = r_dnum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_dnum  <= (mag << FRAC_BITS) + 64'(r_root >> 1);
            r_drem  <= 64'd0;
            r_dcnt  <= 7'd64;
            r_dneg  <= r_v[31];
            r_dbusy <= 1'b1;
            r_ddone <= 1'b0;
        end else if (r_dbusy) begin
            if (r_dcnt == 7'd0) begin
                r_dbusy <= 1'b0;
                r_ddone <= 1'b1;
                if (r_dneg)
                    r_q32 <= (q_fin > 64'h80000000) ? 32'h80000000 : 32'(-q_fin);
                else
                    r_q32 <= (q_fin > 64'h7fffffff) ? 32'h7fffffff : q_fin[31:0];
            end else begin
                if (!trial[64]) begin
                    r_drem <= trial[63:0];
                    r_dnum <= {r_dnum[62:0], 1'b1};
                end else begin
                    r_drem <= {r_drem[62:0], r_dnum[63]};
                    r_dnum <= {r_dnum[62:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 7'd1;
            end
        end
    end
    assign o_status.div_done = r_ddone;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_factor) begin
            if (i_cmd.j < i_cmd.i || !o_status.pivot_pos) r_fac_mem[a_ji] <= 32'd0;
            else r_fac_mem[a_ji] <= r_q32;
        end
    end

    assign o_rd_data = r_fac_q;
endmodule : chol_datapath
`default_nettype wire

>>> rtl/chol_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chol_ctrl
// Sequencer of load, factorization and output of the factorizer.
// ----------------------------------------------------------------------------
module chol_ctrl #(
    parameter int MAX_N = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [3:0]        i_cfg_wdata,
    input  wire logic              i_valid,
    output logic                   o_stall,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [2:0]             o_row_index,
    output logic [2:0]             o_column_index,
    output logic                   o_last_of_run,
    input  wire chol_pkg::t_status i_status,
    output chol_pkg::t_cmd         o_cmd
);
    chol_pkg::t_state r_state, n_state;
    logic [3:0] r_size;
    logic [6:0] r_cnt;
    logic [2:0] r_i, r_j, r_k, r_n1;
    logic [2:0] n_i, n_j, n_k;
    logic [3:0] nact;
    logic [6:0] total;
    logic       r_ov;
    logic [2:0] r_or, r_oc;
    logic       r_ol;

    assign nact = (r_size == 4'd0) ? 4'd1 :
                  (r_size > 4'(MAX_N)) ? 4'(MAX_N) : r_size;
    assign total = {3'd0, nact} * {3'd0, nact};

    logic acc_in;
    assign acc_in = (r_state == chol_pkg::ST_LOAD) && i_valid;
    assign o_stall = (r_state != chol_pkg::ST_LOAD);

    // sqrt/div handshake pulses: issue on state entry
    logic r_sq_go, r_dv_go;

    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        unique case (r_state)
            chol_pkg::ST_LOAD:
                if (acc_in && r_cnt + 7'd1 >= total) begin
                    n_state = chol_pkg::ST_INIT;
                    n_i = 3'd0;
                    n_j = 3'd0;
                end
            chol_pkg::ST_INIT: begin
                n_k = 3'd0;
                if (r_j < r_i) n_state = chol_pkg::ST_WRITE;
                else if (r_i == 3'd0) n_state = chol_pkg::ST_SAT;
                else n_state = chol_pkg::ST_ACC_RD;
            end
            chol_pkg::ST_ACC_RD:  n_state = chol_pkg::ST_ACC_MUL;
            chol_pkg::ST_ACC_MUL: n_state = chol_pkg::ST_ACC_ADD;
            chol_pkg::ST_ACC_ADD: begin
                if (r_k + 3'd1 == r_i) n_state = chol_pkg::ST_SAT;
                else begin
                    n_k = r_k + 3'd1;
                    n_state = chol_pkg::ST_ACC_RD;
                end
            end
            chol_pkg::ST_SAT: n_state = chol_pkg::ST_SQRT;
            chol_pkg::ST_SQRT:
                if (r_j != r_i || !i_status.pivot_pos) n_state = chol_pkg::ST_DIV;
                else if (i_status.sqrt_done && !r_sq_go) n_state = chol_pkg::ST_DIV;
            chol_pkg::ST_DIV:
                if (!i_status.pivot_pos || (i_status.div_done && !r_dv_go))
                    n_state = chol_pkg::ST_WRITE;
            chol_pkg::ST_WRITE: begin
                if (r_j == r_n1) begin
                    n_j = 3'd0;
                    if (r_i == r_n1) begin
                        n_i = 3'd0;
                        n_state = chol_pkg::ST_OUT_RD;
                    end else begin
                        n_i = r_i + 3'd1;
                        n_state = chol_pkg::ST_INIT;
                    end
                end else begin
                    n_j = r_j + 3'd1;
                    n_state = chol_pkg::ST_INIT;
                end
            end
            chol_pkg::ST_OUT_RD: n_state = chol_pkg::ST_OUT_WAIT;
            chol_pkg::ST_OUT_WAIT:
                if (r_ov && !i_stall) begin
                    if (r_ol) n_state = chol_pkg::ST_LOAD;
                    else begin
                        n_state = chol_pkg::ST_OUT_RD;
                        if (r_j == r_n1) begin
                            n_j = 3'd0;
                            n_i = r_i + 3'd1;
                        end else n_j = r_j + 3'd1;
                    end
                end
            default: n_state = chol_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.i = r_i;
        o_cmd.j = r_j;
        o_cmd.k = r_k;
        o_cmd.load_addr = r_cnt[5:0];
        o_cmd.load_wr = acc_in;
        unique case (r_state)
            chol_pkg::ST_INIT: begin
                o_cmd.clr_acc = 1'b1;
                o_cmd.load_addr = 6'({3'd0, r_j} * {2'd0, nact} + {3'd0, r_i});
            end
            chol_pkg::ST_ACC_RD:  o_cmd.acc_rd = 1'b1;
            chol_pkg::ST_ACC_MUL: o_cmd.acc_mul = 1'b1;
            chol_pkg::ST_ACC_ADD: o_cmd.acc_add = 1'b1;
            chol_pkg::ST_SAT:     o_cmd.sat = 1'b1;
            chol_pkg::ST_SQRT:    o_cmd.sqrt_start = r_sq_go && (r_j == r_i);
            chol_pkg::ST_DIV:     o_cmd.div_start = r_dv_go;
            chol_pkg::ST_WRITE:   o_cmd.wr_factor = 1'b1;
            chol_pkg::ST_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                o_cmd.load_addr = 6'({3'd0, r_i} * 6'(MAX_N) + {3'd0, r_j});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chol_pkg::ST_LOAD;
            r_size  <= 4'(MAX_N);
            r_cnt   <= 7'd0;
            r_ov    <= 1'b0;
            r_sq_go <= 1'b1;
            r_dv_go <= 1'b1;
        end else begin
            r_state <= n_state;
            r_sq_go <= (n_state != r_state) || (r_state != chol_pkg::ST_SQRT) ? 1'b1 : 1'b0;
            r_dv_go <= (n_state != r_state) || (r_state != chol_pkg::ST_DIV) ? 1'b1 : 1'b0;
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
                r_cnt  <= 7'd0;
            end else if (acc_in) begin
                r_cnt <= (r_cnt + 7'd1 >= total) ? 7'd0 : r_cnt + 7'd1;
            end
            if (r_state == chol_pkg::ST_OUT_RD) begin
                r_ov <= 1'b1;
                r_or <= r_i;
                r_oc <= r_j;
                r_ol <= (r_i == r_n1) && (r_j == r_n1);
            end else if (r_ov && !i_stall) r_ov <= 1'b0;
        end
        r_i  <= n_i;
        r_j  <= n_j;
        r_k  <= n_k;
        r_n1 <= 3'(nact - 4'd1);
    end

    assign o_valid        = r_ov;
    assign o_row_index    = r_or;
    assign o_column_index = r_oc;
    assign o_last_of_run  = r_ol;
endmodule : chol_ctrl
`default_nettype wire

>>> rtl/cholesky_factorizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cholesky_factorizer
// Streaming Cholesky factorizer for a symmetric matrix in signed fixed point.
// ----------------------------------------------------------------------------
// Load n*n elements row-major on the input channel (i_valid / o_stall); n is
// set by writing i_cfg_we / i_cfg_wdata, which also restarts a partial load.
// While loading, every valid element is taken. After the last element the input
// is stalled while the factor is formed column by column: each lower entry runs
// a multiply-accumulate step per earlier column, each pivot a bit-serial root
// and each lower entry a restoring divide. The factor then leaves row-major as
// n*n items, the last marked by o_last_of_run; each item is read and held until
// it is taken before the next is read. A stall on the output holds the current
// item. Reset sets the size to MAX_N and empties the load count; the stores
// need no clearing.
// ----------------------------------------------------------------------------
module cholesky_factorizer #(
    parameter int MAX_N     = 8,
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [3:0]         i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_matrix_element,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_row_index,
    output logic [2:0]              o_column_index,
    output logic signed [31:0]      o_factor_element,
    output logic                    o_last_of_run
);
    chol_pkg::t_cmd    cmd;
    chol_pkg::t_status status;

    chol_ctrl #(.MAX_N(MAX_N)) u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_valid, .o_stall, .o_valid, .i_stall,
        .o_row_index, .o_column_index, .o_last_of_run,
        .i_status(status), .o_cmd(cmd)
    );

    chol_datapath #(.MAX_N(MAX_N), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_data(i_matrix_element),
        .o_status(status), .o_rd_data(o_factor_element)
    );
endmodule : cholesky_factorizer
`default_nettype wire

>>> tb/sv/cholesky_factorizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cholesky_factorizer_checker
// Watches the size register, the matrix element channel and the factor
// channel. Predicts the lower-triangular factor in fixed point whenever a
// full matrix has been loaded, and compares each factor item in order.
// ----------------------------------------------------------------------------
module cholesky_factorizer_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [3:0]         i_cfg_wdata,
    input  wire logic               i_valid,
    input  wire logic               o_stall,
    input  wire logic signed [31:0] i_matrix_element,
    input  wire logic               o_valid,
    input  wire logic               i_stall,
    input  wire logic [2:0]         o_row_index,
    input  wire logic [2:0]         o_column_index,
    input  wire logic signed [31:0] o_factor_element,
    input  wire logic               o_last_of_run,
    output int                      o_pending,
    output int                      o_errors
);

    localparam int MAX_N = 8;
    localparam int FRAC_BITS = 16;

    typedef struct {
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
        logic               last;
    } t_factor_item;

    t_factor_item factor_q[$];
    logic signed [31:0] matrix_mem[MAX_N*MAX_N];
    longint factor_mem[MAX_N*MAX_N];
    logic [3:0] size_reg;
    int loaded;

    function automatic int order_of(logic [3:0] sz);
        if (sz < 1) return 1;
        if (sz > MAX_N) return MAX_N;
        return sz;
    endfunction

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint round_mul(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

    function automatic longint scale_by_root(longint num, longint unsigned s);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = ((mag << FRAC_BITS) + s / 2) / s;
        if (num < 0) begin
            if (q > 64'h8000_0000) return -64'sd2147483648;
            return -longint'(q);
        end
        if (q > 64'h7fff_ffff) return 64'sd2147483647;
        return longint'(q);
    endfunction

    task automatic predict_factor(int n);
        longint work[MAX_N];
        longint acc;
        longint unsigned root;
        t_factor_item it;
        for (int i = 0; i < n; i++) begin
            root = 0;
            for (int j = 0; j < n; j++) begin
                if (j < i) begin
                    factor_mem[j*n+i] = 0;
                    continue;
                end
                acc = longint'(matrix_mem[j*n+i]);
                for (int k = 0; k < i; k++)
                    acc -= round_mul(factor_mem[i*n+k], factor_mem[j*n+k]);
                work[j] = clamp32(acc);
                if (j == i && work[i] > 0)
                    root = int_sqrt(longint'(work[i]) << FRAC_BITS);
                if (work[i] > 0 && root != 0)
                    factor_mem[j*n+i] = scale_by_root(work[j], root);
                else
                    factor_mem[j*n+i] = 0;
            end
        end
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                it.row = r[2:0];
                it.col = c[2:0];
                it.value = factor_mem[r*n+c][31:0];
                it.last = (r == n - 1) && (c == n - 1);
                factor_q.push_back(it);
            end
        end
    endtask

    always @(posedge i_clk) begin
        int n;
        t_factor_item exp_it;
        if (!i_rst_n) begin
            size_reg = 4'(MAX_N);
            loaded = 0;
            o_errors = 0;
            factor_q.delete();
        end else begin
            if (i_cfg_we) begin
                size_reg = i_cfg_wdata;
                loaded = 0;
            end
            if (i_valid && !o_stall) begin
                n = order_of(size_reg);
                if (loaded >= n * n) loaded = 0;
                matrix_mem[loaded] = i_matrix_element;
                loaded++;
                if (loaded == n * n) begin
                    loaded = 0;
                    predict_factor(n);
                end
            end
            if (o_valid && !i_stall) begin
                if (factor_q.size() == 0) begin
                    $error("unexpected factor item row %0d col %0d value %0d",
                           o_row_index, o_column_index, o_factor_element);
                    o_errors++;
                end else begin
                    exp_it = factor_q.pop_front();
                    if (o_row_index !== exp_it.row) begin
                        $error("row_index: expected %0d, got %0d", exp_it.row, o_row_index);
                        o_errors++;
                    end
                    if (o_column_index !== exp_it.col) begin
                        $error("column_index: expected %0d, got %0d",
                               exp_it.col, o_column_index);
                        o_errors++;
                    end
                    if (o_factor_element !== exp_it.value) begin
                        $error("factor_element: expected %0d, got %0d",
                               exp_it.value, o_factor_element);
                        o_errors++;
                    end
                    if (o_last_of_run !== exp_it.last) begin
                        $error("last_of_run: expected %0d, got %0d",
                               exp_it.last, o_last_of_run);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = factor_q.size();
    end

endmodule

>>> tb/sv/cholesky_factorizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cholesky_factorizer_tb
// Loads symmetric, random and extreme matrices of many sizes under varying
// idle and stall patterns; the checker predicts and compares every factor.
// ----------------------------------------------------------------------------
module cholesky_factorizer_tb;

    localparam int MAX_N = 8;

    typedef enum int {
        MAT_DOMINANT,
        MAT_SYMMETRIC,
        MAT_RAW,
        MAT_EXTREME,
        MAT_NEG_PIVOT
    } t_matrix_kind;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [3:0]         i_cfg_wdata = 4'd0;
    logic               i_valid = 1'b0;
    logic signed [31:0] i_matrix_element = 32'sd0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [2:0]         o_row_index;
    logic [2:0]         o_column_index;
    logic signed [31:0] o_factor_element;
    logic               o_last_of_run;
    int                 pending;
    int                 errors;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 cur_n = MAX_N;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    cholesky_factorizer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall), .i_matrix_element(i_matrix_element),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_row_index(o_row_index), .o_column_index(o_column_index),
        .o_factor_element(o_factor_element), .o_last_of_run(o_last_of_run)
    );

    cholesky_factorizer_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall), .i_matrix_element(i_matrix_element),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_row_index(o_row_index), .o_column_index(o_column_index),
        .o_factor_element(o_factor_element), .o_last_of_run(o_last_of_run),
        .o_pending(pending), .o_errors(errors)
    );

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_element(logic signed [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_matrix_element <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_size(logic [3:0] sz);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= sz;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 4'($urandom());
        cur_n = (sz < 1) ? 1 : (sz > MAX_N) ? MAX_N : sz;
    endtask

    function automatic logic signed [31:0] extreme_value();
        case ($urandom_range(4))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sd0;
            3: return 32'sd1;
            default: return -32'sd1;
        endcase
    endfunction

    task automatic send_matrix(t_matrix_kind kind);
        logic signed [31:0] m[MAX_N][MAX_N];
        int n;
        n = cur_n;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c <= r; c++) begin
                case (kind)
                    MAT_DOMINANT:
                        m[r][c] = (r == c) ? $urandom_range(32'h0100_0000) + n * 32'h0010_0000
                                           : $signed($urandom_range(32'h0020_0000))
                                             - 32'sh0010_0000;
                    MAT_SYMMETRIC, MAT_RAW: m[r][c] = $urandom();
                    MAT_EXTREME: m[r][c] = extreme_value();
                    default:
                        m[r][c] = (r == c && $urandom_range(1)) ? -$signed($urandom_range(32'hfffff))
                                                               : $urandom();
                endcase
                m[c][r] = (kind == MAT_RAW) ? $urandom() : m[r][c];
            end
        end
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_element(m[r][c]);
    endtask

    function automatic t_matrix_kind pick_kind();
        int p;
        p = $urandom_range(99);
        if (p < 60) return MAT_DOMINANT;
        if (p < 72) return MAT_SYMMETRIC;
        if (p < 82) return MAT_RAW;
        if (p < 91) return MAT_NEG_PIVOT;
        return MAT_EXTREME;
    endfunction

    initial begin
        int sent;
        logic [3:0] sz;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_size(4'd0);
        send_element(32'sh7fff_ffff);
        send_element(32'sh8000_0000);
        send_element(32'sd0);
        send_element(32'sd65536);
        write_size(4'd2);
        send_matrix(MAT_EXTREME);
        send_matrix(MAT_NEG_PIVOT);
        write_size(4'd3);
        for (int k = 0; k < 4; k++) send_element($urandom());
        write_size(4'd2);
        send_matrix(MAT_DOMINANT);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 50 : 0;
            recv_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 31 : 0;
            sent = 0;
            while (sent < 75) begin
                if (sent == 0)
                    sz = (phase == 0) ? 4'd15 : (phase == 2) ? 4'd8 : 4'd4;
                else if ($urandom_range(7) == 0)
                    sz = 4'($urandom_range(15));
                else
                    sz = 4'($urandom_range(1, 4));
                write_size(sz);
                for (int k = $urandom_range(1, 3); k > 0 && sent < 75; k--) begin
                    send_matrix(pick_kind());
                    sent += cur_n * cur_n;
                end
            end
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> cholesky_factorizer.f
rtl/chol_pkg.sv
rtl/chol_datapath.sv
rtl/chol_ctrl.sv
rtl/cholesky_factorizer.sv
tb/sv/cholesky_factorizer_checker.sv
tb/sv/cholesky_factorizer_tb.sv
